/* src/assert_macros.svh */
// Shared assertion shorthands; every use samples on clk and is off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/vla_pkg.sv */
package vla_pkg;

  localparam int COORD_BITS       = 13;
  localparam int LENGTH_FRAC_BITS = 4;
  localparam int ANGLE_FRAC_BITS  = 6;
  localparam int CORDIC_STAGES    = 16;

  localparam int TABLE_SIZE = 24;
  localparam int ZFRAC      = 16;
  localparam int GUARD      = 16;

  localparam int ANCHOR_BITS = COORD_BITS - 1;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * COORD_BITS;
  localparam int SQ_BITS     = 2 * COORD_BITS + 1;
  localparam int LENGTH_BITS = COORD_BITS + 1 + LENGTH_FRAC_BITS;
  localparam int RAD_BITS    = 2 * LENGTH_BITS;
  localparam int REM_BITS    = LENGTH_BITS + 2;
  localparam int ANGLE_BITS  = 9 + ANGLE_FRAC_BITS;
  localparam int BASE_BITS   = 7 + ANGLE_FRAC_BITS;
  localparam int XY_BITS     = COORD_BITS + GUARD + 3;
  localparam int Z_BITS      = ZFRAC + 9;

  localparam int ROT_STAGES = (CORDIC_STAGES > TABLE_SIZE) ? TABLE_SIZE : CORDIC_STAGES;

  // Latencies of the two parallel units; the shorter one is padded to match.
  localparam int SQRT_LAT    = LENGTH_BITS + 3;
  localparam int CORDIC_LAT  = ROT_STAGES + 2;
  localparam int CORE_LAT    = (SQRT_LAT > CORDIC_LAT) ? SQRT_LAT : CORDIC_LAT;
  localparam int SQRT_PAD    = CORE_LAT - SQRT_LAT;
  localparam int CORDIC_PAD  = CORE_LAT - CORDIC_LAT;
  localparam int CORE_STAGES = CORE_LAT + 2;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANCHOR_X = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANCHOR_Y = CFG_INDEX_BITS'(1);

  localparam logic [ANCHOR_BITS-1:0] ANCHOR_X_RESET = ANCHOR_BITS'(400);
  localparam logic [ANCHOR_BITS-1:0] ANCHOR_Y_RESET = ANCHOR_BITS'(300);

  localparam logic [ANGLE_BITS-1:0] ANGLE_HALF  = ANGLE_BITS'(180 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0] ANGLE_FULL  = ANGLE_BITS'(360 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_BITS-1:0] ANGLE_RIGHT = ANGLE_BITS'(90 << ANGLE_FRAC_BITS);
  localparam logic [BASE_BITS-1:0]  BASE_RIGHT  = BASE_BITS'(90 << ANGLE_FRAC_BITS);

  localparam logic signed [Z_BITS-1:0] Z_TOP   = Z_BITS'(90 << ZFRAC);
  localparam logic [Z_BITS-1:0]        Z_ROUND = Z_BITS'(1 << (ZFRAC - ANGLE_FRAC_BITS - 1));

  // atan(2^-i) in degrees, ZFRAC fraction bits
  localparam int ATAN_DEG [TABLE_SIZE] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic                  left;
    logic                  below;
    logic                  zero;
  } side_t;

endpackage

/* src/vla_delta.sv */
module vla_delta (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [vla_pkg::COORD_BITS-1:0]  point_x,
  input  logic signed [vla_pkg::COORD_BITS-1:0]  point_y,
  input  logic        [vla_pkg::ANCHOR_BITS-1:0] anchor_x,
  input  logic        [vla_pkg::ANCHOR_BITS-1:0] anchor_y,
  output vla_pkg::side_t                         side
);
  import vla_pkg::*;

  logic [DIFF_BITS-1:0] dx;
  logic [DIFF_BITS-1:0] dy;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= DIFF_BITS'(point_x) - DIFF_BITS'(anchor_x);
      dy <= DIFF_BITS'(point_y) - DIFF_BITS'(anchor_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.ax    <= dx[DIFF_BITS-1] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
      side.ay    <= dy[DIFF_BITS-1] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
      side.left  <= dx[DIFF_BITS-1];
      side.below <= !dy[DIFF_BITS-1] && (dy != '0);
      side.zero  <= (dx == '0) && (dy == '0);
    end
  end

endmodule

/* src/vla_sqrt.sv */
module vla_sqrt (
  input  logic                             clk,
  input  logic                             en,
  input  vla_pkg::side_t                   side,
  output logic [vla_pkg::LENGTH_BITS-1:0]  length
);
  import vla_pkg::*;

  logic [PROD_BITS-1:0]   sq_x;
  logic [PROD_BITS-1:0]   sq_y;
  logic [SQ_BITS-1:0]     sum_sq;
  logic [RAD_BITS-1:0]    rad    [LENGTH_BITS];
  logic [REM_BITS-1:0]    rem    [LENGTH_BITS+1];
  logic [LENGTH_BITS-1:0] root   [LENGTH_BITS+1];
  logic [REM_BITS-1:0]    rem_sh [LENGTH_BITS];
  logic [LENGTH_BITS-1:0] take;
  logic [LENGTH_BITS-1:0] rounded;
  logic [LENGTH_BITS-1:0] len_d  [SQRT_PAD+1];

  assign sum_sq = SQ_BITS'(sq_x) + SQ_BITS'(sq_y);

  // One root bit per stage: bring down two radicand bits, try (root << 2) | 1.
  always_comb begin
    for (int j = 0; j < LENGTH_BITS; j++) begin
      rem_sh[j] = {rem[j][REM_BITS-3:0], rad[j][RAD_BITS-1 -: 2]};
      take[j]   = rem_sh[j] >= {root[j], 2'b01};
    end
  end

  // Round to nearest: bump when the remainder exceeds the root.
  assign rounded = (rem[LENGTH_BITS] > REM_BITS'(root[LENGTH_BITS]))
                 ? root[LENGTH_BITS] + LENGTH_BITS'(1) : root[LENGTH_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x    <= PROD_BITS'(side.ax) * PROD_BITS'(side.ax);
      sq_y    <= PROD_BITS'(side.ay) * PROD_BITS'(side.ay);
      rad[0]  <= RAD_BITS'(sum_sq) << (2 * LENGTH_FRAC_BITS);
      rem[0]  <= '0;
      root[0] <= '0;
      for (int j = 0; j < LENGTH_BITS - 1; j++) begin
        rad[j+1] <= rad[j] << 2;
      end
      for (int j = 0; j < LENGTH_BITS; j++) begin
        if (take[j]) begin
          rem[j+1]  <= rem_sh[j] - {root[j], 2'b01};
          root[j+1] <= {root[j][LENGTH_BITS-2:0], 1'b1};
        end else begin
          rem[j+1]  <= rem_sh[j];
          root[j+1] <= {root[j][LENGTH_BITS-2:0], 1'b0};
        end
      end
      len_d[0] <= rounded;
      for (int k = 1; k <= SQRT_PAD; k++) begin
        len_d[k] <= len_d[k-1];
      end
    end
  end

  assign length = len_d[SQRT_PAD];

endmodule

/* src/vla_cordic.sv */
module vla_cordic (
  input  logic                           clk,
  input  logic                           en,
  input  vla_pkg::side_t                 side,
  output logic [vla_pkg::BASE_BITS-1:0]  base
);
  import vla_pkg::*;

  logic signed [XY_BITS-1:0] x  [ROT_STAGES+1];
  logic signed [XY_BITS-1:0] y  [ROT_STAGES+1];
  logic signed [Z_BITS-1:0]  z  [ROT_STAGES+1];
  logic signed [XY_BITS-1:0] xs [ROT_STAGES];
  logic signed [XY_BITS-1:0] ys [ROT_STAGES];
  logic [ROT_STAGES:0]       horiz;
  logic [ROT_STAGES:0]       vert;
  logic [Z_BITS-1:0]         z_clamp;
  logic [Z_BITS-1:0]         z_round;
  logic [BASE_BITS-1:0]      base_d [CORDIC_PAD+1];

  always_comb begin
    for (int i = 0; i < ROT_STAGES; i++) begin
      xs[i] = x[i] >>> i;
      ys[i] = y[i] >>> i;
    end
  end

  always_comb begin
    if (z[ROT_STAGES][Z_BITS-1]) begin
      z_clamp = '0;
    end else if (z[ROT_STAGES] > Z_TOP) begin
      z_clamp = Z_TOP;
    end else begin
      z_clamp = z[ROT_STAGES];
    end
    z_round = z_clamp + Z_ROUND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]     <= XY_BITS'(side.ax) << GUARD;
      y[0]     <= XY_BITS'(side.ay) << GUARD;
      z[0]     <= '0;
      horiz[0] <= (side.ay == '0);
      vert[0]  <= (side.ax == '0);
      for (int i = 0; i < ROT_STAGES; i++) begin
        horiz[i+1] <= horiz[i];
        vert[i+1]  <= vert[i];
        // drive y toward zero
        if (!y[i][XY_BITS-1]) begin
          x[i+1] <= x[i] + ys[i];
          y[i+1] <= y[i] - xs[i];
          z[i+1] <= z[i] + Z_BITS'(ATAN_DEG[i]);
        end else begin
          x[i+1] <= x[i] - ys[i];
          y[i+1] <= y[i] + xs[i];
          z[i+1] <= z[i] - Z_BITS'(ATAN_DEG[i]);
        end
      end
      if (horiz[ROT_STAGES]) begin
        base_d[0] <= '0;
      end else if (vert[ROT_STAGES]) begin
        base_d[0] <= BASE_RIGHT;
      end else begin
        base_d[0] <= z_round[ZFRAC-ANGLE_FRAC_BITS +: BASE_BITS];
      end
      for (int k = 1; k <= CORDIC_PAD; k++) begin
        base_d[k] <= base_d[k-1];
      end
    end
  end

  assign base = base_d[CORDIC_PAD];

endmodule

/* src/vla_fold.sv */
module vla_fold (
  input  logic                             clk,
  input  logic                             en,
  input  vla_pkg::side_t                   side,
  input  logic [vla_pkg::BASE_BITS-1:0]    base,
  input  logic [vla_pkg::LENGTH_BITS-1:0]  len_in,
  output logic [vla_pkg::COORD_BITS-1:0]   abs_dx,
  output logic [vla_pkg::COORD_BITS-1:0]   abs_dy,
  output logic                             left_of_anchor,
  output logic                             below_anchor,
  output logic [vla_pkg::LENGTH_BITS-1:0]  length,
  output logic [vla_pkg::ANGLE_BITS-1:0]   angle_ccw,
  output logic [vla_pkg::ANGLE_BITS-1:0]   cw_angle,
  output logic                             zero_vector
);
  import vla_pkg::*;

  logic [ANGLE_BITS-1:0] base_w;
  logic [ANGLE_BITS-1:0] ccw;
  logic [ANGLE_BITS-1:0] cw;

  assign base_w = ANGLE_BITS'(base);

  // Fold the first-quadrant angle; y grows downward, so "below" is positive dy.
  always_comb begin
    priority if (side.left && side.below) begin
      ccw = ANGLE_HALF + base_w;
    end else if (side.left) begin
      ccw = ANGLE_HALF - base_w;
    end else if (side.below) begin
      ccw = ANGLE_FULL - base_w;
    end else begin
      ccw = base_w;
    end
    cw = ANGLE_FULL - ccw;
    if (side.zero) begin
      ccw = '0;
      cw  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_dx         <= side.ax;
      abs_dy         <= side.ay;
      left_of_anchor <= side.left;
      below_anchor   <= side.below;
      length         <= len_in;
      angle_ccw      <= ccw;
      cw_angle       <= cw;
      zero_vector    <= side.zero;
    end
  end

endmodule

/* src/vector_to_length_and_angle_unit.sv */
// Channel  | Signals                            | Taken when
// ---------+------------------------------------+-------------------------
// in       | in_valid, in_stall, point_x/y      | in_valid && !in_stall
// out      | out_valid, out_stall, result ports | out_valid && !out_stall
// cfg      | cfg_write_en, cfg_index, cfg_data  | cfg_write_en
//
// One item enters per cycle while in_stall is low; the square-root pipeline,
// one root bit per stage, is the longer unit and sets the result's delay; it
// runs beside the CORDIC rotation stages.
// Reset clears the valid bits and loads the anchor to (400, 300).
// A stalled result holds in the output register; the core keeps taking items
// until its last stage is full, and only then is in_stall raised.
module vector_to_length_and_angle_unit (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic signed [vla_pkg::COORD_BITS-1:0]      point_x,
  input  logic signed [vla_pkg::COORD_BITS-1:0]      point_y,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic        [vla_pkg::COORD_BITS-1:0]      abs_dx,
  output logic        [vla_pkg::COORD_BITS-1:0]      abs_dy,
  output logic                                       left_of_anchor,
  output logic                                       below_anchor,
  output logic        [vla_pkg::LENGTH_BITS-1:0]     length,
  output logic        [vla_pkg::ANGLE_BITS-1:0]      angle_ccw,
  output logic        [vla_pkg::ANGLE_BITS-1:0]      cw_angle,
  output logic                                       zero_vector,
  input  logic                                       cfg_write_en,
  input  logic        [vla_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic        [vla_pkg::ANCHOR_BITS-1:0]     cfg_data
);
  import vla_pkg::*;

  logic [ANCHOR_BITS-1:0] anchor_x;
  logic [ANCHOR_BITS-1:0] anchor_y;
  logic [CORE_STAGES-1:0] core_v;
  logic                   en_core;
  logic                   en_out;
  side_t                  side;
  side_t                  side_d [CORE_LAT];
  logic [LENGTH_BITS-1:0] len_core;
  logic [BASE_BITS-1:0]   base;

  assign en_out   = !out_valid || !out_stall;
  assign en_core  = !core_v[CORE_STAGES-1] || en_out;
  assign in_stall = !en_core;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x <= ANCHOR_X_RESET;
      anchor_y <= ANCHOR_Y_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_ANCHOR_X: anchor_x <= cfg_data;
        REG_ANCHOR_Y: anchor_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      core_v    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en_core) begin
        core_v <= {core_v[CORE_STAGES-2:0], in_valid};
      end
      if (en_out) begin
        out_valid <= core_v[CORE_STAGES-1];
      end
    end
  end

  // Carry magnitudes and flags alongside the two arithmetic units.
  always_ff @(posedge clk) begin
    if (en_core) begin
      side_d[0] <= side;
      for (int k = 1; k < CORE_LAT; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  vla_delta u_delta (
    .clk      (clk),
    .en       (en_core),
    .point_x  (point_x),
    .point_y  (point_y),
    .anchor_x (anchor_x),
    .anchor_y (anchor_y),
    .side     (side)
  );

  vla_sqrt u_sqrt (
    .clk    (clk),
    .en     (en_core),
    .side   (side),
    .length (len_core)
  );

  vla_cordic u_cordic (
    .clk  (clk),
    .en   (en_core),
    .side (side),
    .base (base)
  );

  vla_fold u_fold (
    .clk            (clk),
    .en             (en_out),
    .side           (side_d[CORE_LAT-1]),
    .base           (base),
    .len_in         (len_core),
    .abs_dx         (abs_dx),
    .abs_dy         (abs_dy),
    .left_of_anchor (left_of_anchor),
    .below_anchor   (below_anchor),
    .length         (length),
    .angle_ccw      (angle_ccw),
    .cw_angle       (cw_angle),
    .zero_vector    (zero_vector)
  );

`include "assert_macros.svh"

  `VLA_ASSERT_IMP(a_zero_clears, out_valid && zero_vector,
    (angle_ccw == '0) && (cw_angle == '0) && (length == '0),
    "zero vector with nonzero angle or length")
  `VLA_ASSERT_IMP(a_angles_sum, out_valid && !zero_vector,
    int'(angle_ccw) + int'(cw_angle) == int'(ANGLE_FULL),
    "ccw and cw angles do not add to a full turn")
  `VLA_ASSERT_IMP(a_first_quadrant,
    out_valid && !zero_vector && !left_of_anchor && !below_anchor,
    angle_ccw <= ANGLE_RIGHT, "first-quadrant angle above 90 degrees")
  `VLA_ASSERT_IMP(a_stall_only_full, in_stall,
    core_v[CORE_STAGES-1] && out_valid && out_stall,
    "input stalled while the pipeline can move")
  `VLA_ASSERT_NEXT(a_out_loads, core_v[CORE_STAGES-1] && en_out, out_valid,
    "finished item did not reach the output register")

endmodule
